// ----- hw/rtl/gcr35_pkg.sv -----
package gcr35_pkg;

    localparam int unsigned SECTOR_BYTES = 524;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned SUM_W        = 9;
    localparam int unsigned SIX_W        = 6;
    localparam int unsigned BURST_MAX    = 7;
    localparam int unsigned CNT_W        = 3;

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(SECTOR_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_GROUP  = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_SECTOR = CNT_W'(BURST_MAX);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    typedef struct packed {
        logic                          wr;
        logic                          sector;
        logic [CNT_W-1:0]              cnt;
        logic [BURST_MAX-1:0][SIX_W-1:0] six;
    } gcr35_burst_t;

    localparam logic [7:0] WRITE_TABLE [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    function automatic logic [7:0] gcr35_code(input logic [SIX_W-1:0] six);
        return WRITE_TABLE[six];
    endfunction

    function automatic logic [SIX_W-1:0] pack_tops(input logic [7:0] hi,
                                                   input logic [7:0] mid,
                                                   input logic [7:0] lo);
        return {hi[7:6], mid[7:6], lo[7:6]};
    endfunction

endpackage

// ----- hw/rtl/gcr35_core.sv -----
module gcr35_core
    import gcr35_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   data_byte,
    input  logic         data_valid,
    output logic         data_stall,
    input  logic         burst_busy,
    output gcr35_burst_t burst
);

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       held_first_reg, held_first_next;
    logic [7:0]       held_second_reg, held_second_next;
    logic [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic [SUM_W-1:0] sum_c_reg, sum_c_next;

    logic       last_pos;
    logic       emits;
    logic       s1_go;
    logic       accept;
    logic [7:0] third;

    assign last_pos   = (pos_reg == LAST_POS);
    assign emits      = (phase_reg == PH_THIRD) || last_pos;
    assign s1_go      = s1_valid_reg && (!emits || !burst_busy);
    assign data_stall = s1_valid_reg && !s1_go;
    assign accept     = data_valid && !data_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // checksum step and burst contents for the byte in the input register
    always_comb
    begin
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        sum_c_next       = sum_c_reg;
        third            = '0;
        burst            = '0;

        if (s1_go)
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (phase_reg)
                PH_FIRST:
                begin
                    // rotate left through bit seven; carry goes to sum_c
                    sum_a_next = {1'b0, sum_a_reg[6:0], sum_a_reg[7]};
                    sum_c_next = SUM_W'(sum_c_reg + {1'b0, s1_byte_reg}
                                        + {8'b0, sum_a_reg[7]});
                    held_first_next = s1_byte_reg ^ {sum_a_reg[6:0], sum_a_reg[7]};
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    sum_b_next = SUM_W'(sum_b_reg + {1'b0, s1_byte_reg}
                                        + {8'b0, sum_c_reg[8]});
                    sum_c_next = {1'b0, sum_c_reg[7:0]};
                    held_second_next = s1_byte_reg ^ sum_c_reg[7:0];
                    phase_next = PH_THIRD;
                    if (last_pos)
                    begin
                        burst.wr     = 1'b1;
                        burst.sector = 1'b1;
                        burst.cnt    = CNT_SECTOR;
                        burst.six[0] = pack_tops(held_first_reg,
                                                 held_second_next, 8'h00);
                        burst.six[1] = held_first_reg[SIX_W-1:0];
                        burst.six[2] = held_second_next[SIX_W-1:0];
                        burst.six[3] = pack_tops(sum_c_next[7:0], sum_b_next[7:0],
                                                 sum_a_reg[7:0]);
                        burst.six[4] = sum_c_next[SIX_W-1:0];
                        burst.six[5] = sum_b_next[SIX_W-1:0];
                        burst.six[6] = sum_a_reg[SIX_W-1:0];
                        pos_next         = '0;
                        phase_next       = PH_FIRST;
                        held_first_next  = '0;
                        held_second_next = '0;
                        sum_a_next       = '0;
                        sum_b_next       = '0;
                        sum_c_next       = '0;
                    end
                end
                PH_THIRD:
                begin
                    sum_a_next = SUM_W'(sum_a_reg + {1'b0, s1_byte_reg}
                                        + {8'b0, sum_b_reg[8]});
                    sum_b_next = {1'b0, sum_b_reg[7:0]};
                    third      = s1_byte_reg ^ sum_b_reg[7:0];
                    phase_next = PH_FIRST;
                    burst.wr     = 1'b1;
                    burst.cnt    = CNT_GROUP;
                    burst.six[0] = pack_tops(held_first_reg, held_second_reg, third);
                    burst.six[1] = held_first_reg[SIX_W-1:0];
                    burst.six[2] = held_second_reg[SIX_W-1:0];
                    burst.six[3] = third[SIX_W-1:0];
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            pos_reg         <= '0;
            phase_reg       <= PH_FIRST;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            sum_c_reg       <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            sum_c_reg       <= sum_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
        end
    end

endmodule

// ----- hw/rtl/gcr35_burst.sv -----
module gcr35_burst
    import gcr35_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  gcr35_burst_t burst,
    output logic         burst_busy,
    output logic         disk_valid,
    input  logic         disk_stall,
    output logic [7:0]   disk_byte,
    output logic         sector_end,
    output logic         run_last
);

    logic [BURST_MAX-1:0][SIX_W-1:0] six_reg, six_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            sector_reg, sector_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg;
    logic                            out_end_reg;
    logic                            out_last_reg;
    logic                            out_take;
    logic                            pop;

    assign burst_busy = (cnt_reg != '0);
    assign out_take   = !out_valid_reg || !disk_stall;
    assign pop        = out_take && burst_busy;

    always_comb
    begin
        six_next       = six_reg;
        cnt_next       = cnt_reg;
        sector_next    = sector_reg;
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = burst_busy;
        end
        if (burst.wr)
        begin
            six_next    = burst.six;
            cnt_next    = burst.cnt;
            sector_next = burst.sector;
        end
        else if (pop)
        begin
            six_next = six_reg >> SIX_W;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sector_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sector_reg    <= sector_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        six_reg <= six_next;
        if (pop)
        begin
            out_byte_reg <= gcr35_code(six_reg[0]);
            out_last_reg <= (cnt_reg == CNT_W'(1));
            out_end_reg  <= sector_reg && (cnt_reg == CNT_W'(1));
        end
    end

    assign disk_valid = out_valid_reg;
    assign disk_byte  = out_byte_reg;
    assign sector_end = out_end_reg;
    assign run_last   = out_last_reg;

endmodule

// ----- hw/rtl/gcr35_sector_data_encoder.sv -----
// 3.5-inch GCR 6-and-2 sector data encoder.
//
// Input channel: data_byte / data_valid / data_stall, one sector byte per beat,
// 524 beats per sector (12 tag bytes, then 512 data bytes).
// Output channel: disk_byte / sector_end / run_last with disk_valid / disk_stall,
// one coded disk byte per beat. Every third input byte yields four beats; the
// last byte of a sector yields seven (three data, four checksum), with
// sector_end on the final one. run_last marks the last beat of each burst.
//
// An accepted byte is held in the input register; its burst is then written
// into the burst buffer, from which its first disk byte is registered out.
// Throughput: input bytes are taken every cycle until a byte that emits finds
// the burst buffer still draining. A burst is loaded only after the previous
// one has fully left the buffer, so disk_valid drops between bursts.
//
// Reset clears the byte position, the checksum accumulators and both
// channels. When the receiver stalls, the output beat holds; the burst buffer
// and then the input register fill and data_stall rises.
module gcr35_sector_data_encoder
    import gcr35_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       data_valid,
    output logic       data_stall,
    output logic [7:0] disk_byte,
    output logic       sector_end,
    output logic       run_last,
    output logic       disk_valid,
    input  logic       disk_stall
);

    gcr35_burst_t burst;
    logic         burst_busy;

    gcr35_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .burst_busy (burst_busy),
        .burst      (burst)
    );

    gcr35_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .burst_busy (burst_busy),
        .disk_valid (disk_valid),
        .disk_stall (disk_stall),
        .disk_byte  (disk_byte),
        .sector_end (sector_end),
        .run_last   (run_last)
    );

endmodule

// ----- hw/rtl/gcr35_checker.sv -----
module gcr35_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] data_byte,
    input logic       data_valid,
    input logic       data_stall,
    input logic [7:0] disk_byte,
    input logic       sector_end,
    input logic       run_last,
    input logic       disk_valid,
    input logic       disk_stall
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disk_valid && disk_stall |=> disk_valid && $stable(disk_byte)
            && $stable(sector_end) && $stable(run_last))
        else $error("stalled disk beat changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_stall |=> data_valid && $stable(data_byte))
        else $error("stalled sector beat changed");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        disk_valid && sector_end |-> run_last)
        else $error("sector_end without run_last");

    // every write table code has the top bit set
    a_code_msb: assert property (@(posedge clk) disable iff (!rst_n)
        disk_valid |-> disk_byte[7])
        else $error("disk byte outside write table");

    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !disk_valid)
        else $error("disk beat right after reset");

endmodule

bind gcr35_sector_data_encoder gcr35_checker u_gcr35_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (data_byte),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .disk_byte  (disk_byte),
    .sector_end (sector_end),
    .run_last   (run_last),
    .disk_valid (disk_valid),
    .disk_stall (disk_stall)
);
